@@ rtl/ppd_pkg.sv @@
package ppd_pkg;

  // Widths fixed by the item fields and by the largest supported table.
  localparam int TICK_W   = 32;
  localparam int PRIO_W   = 8;
  localparam int SLOT_W   = 6;
  localparam int CNT_W    = SLOT_W + 1;
  localparam int MAX_RUNS = 8;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_ADD     = 2'd1;
  localparam logic [1:0] FUNC_ENABLE  = 2'd2;
  localparam logic [1:0] FUNC_DISABLE = 2'd3;

  localparam logic [2:0] KIND_RUN    = 3'd0;
  localparam logic [2:0] KIND_ADDED  = 3'd1;
  localparam logic [2:0] KIND_FULL   = 3'd2;
  localparam logic [2:0] KIND_BADARG = 3'd3;
  localparam logic [2:0] KIND_DONE   = 3'd4;
  localparam logic [2:0] KIND_NOSLOT = 3'd5;

  // Best candidate found so far, moving one cell along the row each cycle.
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [SLOT_W-1:0] slot;
  } wave_t;

  // Commands broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              add_en;
    logic              en_wr;
    logic              en_val;
    logic              stamp_en;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] period;
    logic [PRIO_W-1:0] prio;
    logic [TICK_W-1:0] tick;
  } cmd_t;

endpackage

@@ rtl/ppd_cell.sv @@
module ppd_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  ppd_pkg::cmd_t               cmd,
  input  logic [ppd_pkg::CNT_W-1:0]   fill_count,
  input  logic [ppd_pkg::SLOT_W-1:0]  idx,
  input  ppd_pkg::wave_t              wave_in,
  output ppd_pkg::wave_t              wave_out
);

  logic [ppd_pkg::TICK_W-1:0] period;
  logic [ppd_pkg::TICK_W-1:0] last_run;
  logic [ppd_pkg::PRIO_W-1:0] prio;
  logic                       enable;

  logic                       hit;
  logic                       filled;
  logic [ppd_pkg::TICK_W-1:0] elapsed;
  logic                       cand;
  logic                       take;

  assign hit     = (cmd.slot == idx);
  assign filled  = (ppd_pkg::CNT_W'(idx) < fill_count);
  assign elapsed = cmd.tick - last_run;
  assign cand    = filled && enable && (elapsed >= period);
  // A strictly lower priority wins, so on a tie the earlier slot is kept.
  assign take    = cand && (!wave_in.valid || (prio < wave_in.prio));

  always_ff @(posedge clk) begin
    if (cmd.add_en && hit) begin
      period   <= cmd.period;
      last_run <= '0;
      prio     <= cmd.prio;
      enable   <= 1'b1;
    end
    if (cmd.en_wr && hit) begin
      enable <= cmd.en_val;
    end
    if (cmd.stamp_en && hit) begin
      last_run <= cmd.tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out <= '0;
    end else if (take) begin
      wave_out <= '{valid: 1'b1, prio: prio, slot: idx};
    end else begin
      wave_out <= wave_in;
    end
  end

endmodule

@@ rtl/periodic_priority_task_dispatcher.sv @@
// Add, enable and disable transactions: the result is registered in the hold register and
// then in the output register once the output is free. Tick transactions: each search for
// the next due task runs through the cell row; each run found is held until the next
// search shows whether another follows, and at most eight tasks run per tick. A tick with
// no due task returns to idle with no result. One input transaction is in work at a time.
// Reset (rst, synchronous, active high) clears the tick, the fill count and control state.
module periodic_priority_task_dispatcher #(
  parameter int NUM_TASKS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // task_slot[2:0], task_period[34:3], task_priority[42:35], handler_present[43]
  input  logic [47:0] s_tdata,
  // func[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // slot_out[2:0], tick_now[34:3]
  output logic [39:0] m_tdata,
  // kind[2:0]
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  // The fill count and the wait counter both need to hold NUM_TASKS itself.
  localparam int CW = $clog2(NUM_TASKS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // Unpacked input fields.
  logic [1:0]  func;
  logic [2:0]  task_slot;
  logic [31:0] task_period;
  logic [7:0]  task_priority;
  logic        handler_present;

  assign func            = s_tuser;
  assign task_slot       = s_tdata[2:0];
  assign task_period     = s_tdata[34:3];
  assign task_priority   = s_tdata[42:35];
  assign handler_present = s_tdata[43];

  // Sequencer registers and their next values.
  logic [1:0]              state, state_next;
  logic [CW-1:0]           cnt, cnt_next;
  logic [3:0]              runs, runs_next;
  logic [CW-1:0]           filled_count, filled_count_next;
  logic [31:0]             tick_count, tick_count_next;
  logic                    hold_valid, hold_valid_next;
  logic [2:0]              hold_kind, hold_kind_next;
  logic [2:0]              hold_slot, hold_slot_next;

  // Output register.
  logic [2:0]              out_kind;
  logic [2:0]              out_slot;
  logic                    out_last;
  logic [31:0]             out_tick;

  logic                    in_acc;
  logic                    out_free;
  logic                    out_load;
  logic                    load_last;
  logic                    full;
  logic                    noslot;
  ppd_pkg::cmd_t           cmd;
  ppd_pkg::wave_t          wave [NUM_TASKS+1];
  ppd_pkg::wave_t          chain_end;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign full     = (filled_count >= CW'(NUM_TASKS));
  assign noslot   = (8'(task_slot) >= 8'(filled_count));

  // The cell row. Each cell holds one slot and hands the best due candidate seen so far
  // to its right-hand neighbour every cycle. Because the slot index rises along the row
  // and only a strictly lower priority replaces the candidate, what leaves the last cell
  // is the next task in dispatch order once the row has settled.
  assign wave[0]   = '0;
  assign chain_end = wave[NUM_TASKS];

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    ppd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .fill_count (ppd_pkg::CNT_W'(filled_count)),
      .idx        (ppd_pkg::SLOT_W'(i)),
      .wave_in    (wave[i]),
      .wave_out   (wave[i+1])
    );
  end

  // Sequencer. A result is held back in the hold register until the next search shows
  // whether another run follows, so that the final result of a transaction carries tlast.
  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    runs_next         = runs;
    filled_count_next = filled_count;
    tick_count_next   = tick_count;
    hold_valid_next   = hold_valid;
    hold_kind_next    = hold_kind;
    hold_slot_next    = hold_slot;
    out_load          = 1'b0;
    load_last         = 1'b0;
    cmd               = '0;
    cmd.tick          = tick_count;
    cmd.period        = task_period;
    cmd.prio          = task_priority;

    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (func) inside
            ppd_pkg::FUNC_TICK: begin
              tick_count_next = tick_count + 32'd1;
              cnt_next        = '0;
              runs_next       = '0;
              hold_valid_next = 1'b0;
              state_next      = ST_SCAN;
            end
            ppd_pkg::FUNC_ADD: begin
              hold_valid_next = 1'b1;
              state_next      = ST_FLUSH;
              if (full) begin
                hold_kind_next = ppd_pkg::KIND_FULL;
                hold_slot_next = 3'd0;
              end else if (!handler_present || (task_period == 32'd0)) begin
                hold_kind_next = ppd_pkg::KIND_BADARG;
                hold_slot_next = 3'd0;
              end else begin
                hold_kind_next    = ppd_pkg::KIND_ADDED;
                hold_slot_next    = 3'(filled_count);
                cmd.add_en        = 1'b1;
                cmd.slot          = ppd_pkg::SLOT_W'(filled_count);
                filled_count_next = filled_count + 1'b1;
              end
            end
            ppd_pkg::FUNC_ENABLE, ppd_pkg::FUNC_DISABLE: begin
              hold_valid_next = 1'b1;
              hold_slot_next  = task_slot;
              state_next      = ST_FLUSH;
              if (noslot) begin
                hold_kind_next = ppd_pkg::KIND_NOSLOT;
              end else begin
                hold_kind_next = ppd_pkg::KIND_DONE;
                cmd.en_wr      = 1'b1;
                cmd.en_val     = (func == ppd_pkg::FUNC_ENABLE);
                cmd.slot       = ppd_pkg::SLOT_W'(task_slot);
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt != CW'(NUM_TASKS)) begin
          cnt_next = cnt + 1'b1;
        end else if (chain_end.valid) begin
          // A further due task: release the held run without tlast, hold the new one,
          // stamp it and let the row settle again.
          if (!hold_valid || out_free) begin
            out_load        = hold_valid;
            hold_valid_next = 1'b1;
            hold_kind_next  = ppd_pkg::KIND_RUN;
            hold_slot_next  = chain_end.slot[2:0];
            cmd.stamp_en    = 1'b1;
            cmd.slot        = chain_end.slot;
            runs_next       = runs + 4'd1;
            cnt_next        = '0;
            if (runs == 4'(ppd_pkg::MAX_RUNS - 1)) begin
              state_next = ST_FLUSH;
            end
          end
        end else begin
          state_next = hold_valid ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load        = 1'b1;
          load_last       = 1'b1;
          hold_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      runs         <= '0;
      filled_count <= '0;
      tick_count   <= '0;
      hold_valid   <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      runs         <= runs_next;
      filled_count <= filled_count_next;
      tick_count   <= tick_count_next;
      hold_valid   <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    hold_kind <= hold_kind_next;
    hold_slot <= hold_slot_next;
  end

  // Output register: the tick is captured at load time, which is still the value left by
  // the transaction that caused the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind <= hold_kind;
      out_slot <= hold_slot;
      out_last <= load_last;
      out_tick <= tick_count;
    end
  end

  assign m_tdata = {5'd0, out_tick, out_slot};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  // An accepted transaction always takes the sequencer out of idle.
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state != ST_IDLE))
    else $error("sequencer stayed idle after an input transaction");

  // The final result can only be released from a filled hold register.
  a_flush_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> hold_valid)
    else $error("flush without a held result");

  // No more than the run limit is ever dispatched for one tick.
  a_run_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.stamp_en |-> (runs < 4'(ppd_pkg::MAX_RUNS)) && chain_end.valid)
    else $error("run stamped beyond the limit");

  // The table fills one slot at a time and never beyond its size.
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((filled_count == $past(filled_count)) ||
              (filled_count == CW'($past(filled_count) + 1'b1))) &&
             (filled_count <= CW'(NUM_TASKS)))
    else $error("fill count stepped wrongly");

endmodule

@@ tb/periodic_priority_task_dispatcher_tb.sv @@
module periodic_priority_task_dispatcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The table size is kept at the value the slot field can address in full.
  localparam int TABLE_SIZE    = 8;
  localparam int PRIO_LEVELS   = 256;
  // The quiet at the end is longer than a tick that dispatches eight tasks
  // takes while the receiver keeps up.
  localparam int DRAIN_CYCLES  = 100;
  // The receiver's long hold-off in the back-pressure test.
  localparam int PRESSURE_HOLD = 400;
  // The slowest legal run is roughly 360 items each taking a full tick, a long
  // sender gap and eight results each waiting out the longest receiver stall.
  // The limit sits several times above that.
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 300;

  // One result as it leaves the block.
  typedef struct packed {
    logic [2:0]                 kind;
    logic [2:0]                 slot;
    logic                       last;
    logic [ppd_pkg::TICK_W-1:0] tick;
  } dispatch_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = ppd_pkg::FUNC_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  periodic_priority_task_dispatcher #(
    .NUM_TASKS(TABLE_SIZE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // Our own picture of the task table, updated as each input transaction is
  // accepted. Entries beyond the fill count are never looked at.
  int unsigned                sched_filled;
  logic [ppd_pkg::TICK_W-1:0] sched_tick;
  logic [ppd_pkg::TICK_W-1:0] slot_period   [TABLE_SIZE];
  logic [ppd_pkg::TICK_W-1:0] slot_last_run [TABLE_SIZE];
  logic [ppd_pkg::PRIO_W-1:0] slot_prio     [TABLE_SIZE];
  logic                       slot_enabled  [TABLE_SIZE];

  // Results that the block still owes us, oldest first.
  dispatch_result_t pending_results[$];

  int  errors       = 0;
  int  cycle_count  = 0;
  // When set, neither side inserts random idle cycles; a stall already under way still runs out.
  bit  no_idle      = 1'b0;
  // Raised once by the back-pressure test; the receiver picks it up itself.
  bit  hold_go      = 1'b0;
  bit  hold_done    = 1'b0;
  int  stall_left   = 0;

  // Works out every result that one accepted input transaction causes and
  // appends them to the pending queue, with the final one marked as last.
  function automatic void predict_dispatch(input logic [1:0] func,
                                           input logic [2:0] slot,
                                           input logic [ppd_pkg::TICK_W-1:0] period,
                                           input logic [ppd_pkg::PRIO_W-1:0] prio,
                                           input logic handler);
    dispatch_result_t batch[$];
    dispatch_result_t res;
    int               n;

    n = 0;
    case (func)
      ppd_pkg::FUNC_TICK: begin
        sched_tick = sched_tick + 32'd1;
        // Walk priorities from lowest upwards and slots in order within each,
        // so that runs come out in dispatch order.
        for (int p = 0; p < PRIO_LEVELS; p++) begin
          for (int i = 0; i < sched_filled; i++) begin
            if (n < ppd_pkg::MAX_RUNS && slot_enabled[i] &&
                slot_prio[i] == ppd_pkg::PRIO_W'(p) &&
                (sched_tick - slot_last_run[i]) >= slot_period[i]) begin
              slot_last_run[i] = sched_tick;
              res = '{kind: ppd_pkg::KIND_RUN, slot: 3'(i), last: 1'b0, tick: sched_tick};
              batch.push_back(res);
              n++;
            end
          end
        end
      end
      ppd_pkg::FUNC_ADD: begin
        // Fullness wins over bad arguments.
        if (sched_filled >= TABLE_SIZE) begin
          res = '{kind: ppd_pkg::KIND_FULL, slot: 3'd0, last: 1'b0, tick: sched_tick};
        end else if (!handler || period == '0) begin
          res = '{kind: ppd_pkg::KIND_BADARG, slot: 3'd0, last: 1'b0, tick: sched_tick};
        end else begin
          slot_period[sched_filled]   = period;
          slot_last_run[sched_filled] = '0;
          slot_prio[sched_filled]     = prio;
          slot_enabled[sched_filled]  = 1'b1;
          res = '{kind: ppd_pkg::KIND_ADDED, slot: 3'(sched_filled), last: 1'b0,
                  tick: sched_tick};
          sched_filled++;
        end
        batch.push_back(res);
      end
      default: begin
        if (slot >= sched_filled) begin
          res = '{kind: ppd_pkg::KIND_NOSLOT, slot: slot, last: 1'b0, tick: sched_tick};
        end else begin
          slot_enabled[slot] = (func == ppd_pkg::FUNC_ENABLE);
          res = '{kind: ppd_pkg::KIND_DONE, slot: slot, last: 1'b0, tick: sched_tick};
        end
        batch.push_back(res);
      end
    endcase
    if (batch.size() > 0) begin
      batch[batch.size()-1].last = 1'b1;
    end
    foreach (batch[k]) begin
      pending_results.push_back(batch[k]);
    end
  endfunction

  // Offers one input transaction, possibly after a random gap, and returns
  // once it has been accepted. The prediction is made at acceptance.
  task automatic send_item(input logic [1:0] func, input logic [2:0] slot,
                           input logic [ppd_pkg::TICK_W-1:0] period,
                           input logic [ppd_pkg::PRIO_W-1:0] prio, input logic handler);
    int pick;
    int gap;

    pick = $urandom_range(0, 99);
    if (no_idle || pick < 50) begin
      gap = 0;
    end else if (pick < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {4'b0, handler, prio, period, slot};
    s_tuser  <= func;
    s_tvalid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!s_tready);
    predict_dispatch(func, slot, period, prio, handler);
  endtask

  task automatic send_tick();
    send_item(ppd_pkg::FUNC_TICK, 3'($urandom_range(0, 7)), $urandom,
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_add(input logic [ppd_pkg::TICK_W-1:0] period,
                          input logic [ppd_pkg::PRIO_W-1:0] prio,
                          input logic handler);
    send_item(ppd_pkg::FUNC_ADD, 3'($urandom_range(0, 7)), period, prio, handler);
  endtask

  task automatic send_switch(input logic [1:0] func, input logic [2:0] slot);
    send_item(func, slot, $urandom, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // With nothing in the table every switch addresses a missing slot, a tick
  // dispatches nothing, and adds with no handler or a zero period bounce.
  task automatic test_empty_table();
    no_idle = 1'b1;
    send_switch(ppd_pkg::FUNC_ENABLE, 3'd0);
    send_switch(ppd_pkg::FUNC_DISABLE, 3'd7);
    send_tick();
    send_add($urandom | 32'h1, 8'($urandom_range(0, 255)), 1'b0);
    send_add(32'd0, 8'($urandom_range(0, 255)), 1'b1);
    no_idle = 1'b0;
  endtask

  // Fills all eight slots. The mix gives equal priorities (so that slot order
  // decides), both priority extremes, the largest period, and short periods
  // that keep the dispatcher busy for the rest of the run.
  task automatic test_fill_table();
    send_add(32'd1, 8'd255, 1'b1);
    send_tick();
    // Slot 1 is just past the filled region.
    send_switch(ppd_pkg::FUNC_ENABLE, 3'd1);
    send_add(32'd2, 8'd0, 1'b1);
    send_add(32'd3, 8'd7, 1'b1);
    send_add(32'd1, 8'd7, 1'b1);
    send_tick();
    send_add(32'hFFFF_FFFF, 8'd0, 1'b1);
    send_add(32'd4, 8'd128, 1'b1);
    send_add(32'($urandom_range(1, 6)), 8'($urandom_range(0, 255)), 1'b1);
    send_add($urandom | 32'h1, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // A full table refuses an add even when its arguments are also bad.
  task automatic test_full_table();
    send_add(32'd1, 8'd0, 1'b1);
    send_add(32'd0, 8'd255, 1'b0);
  endtask

  task automatic test_enable_disable();
    send_switch(ppd_pkg::FUNC_DISABLE, 3'd3);
    send_tick();
    send_switch(ppd_pkg::FUNC_ENABLE, 3'd3);
    send_switch(ppd_pkg::FUNC_DISABLE, 3'd0);
    send_tick();
    send_switch(ppd_pkg::FUNC_ENABLE, 3'd0);
  endtask

  // The receiver stops taking results for a long stretch while ticks keep
  // coming, so the block has to hold its output and stall its input.
  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_go = 1'b1;
    repeat (24) send_tick();
    no_idle = 1'b0;
  endtask

  // Mostly ticks, so that runs dominate, with switches toggling tasks on and
  // off and the odd add against the full table carrying random fields.
  task automatic test_random_mix();
    int pick;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_tick();
      end else if (pick < 76) begin
        send_switch(ppd_pkg::FUNC_ENABLE, 3'($urandom_range(0, 7)));
      end else if (pick < 90) begin
        send_switch(ppd_pkg::FUNC_DISABLE, 3'($urandom_range(0, 7)));
      end else begin
        send_add(($urandom_range(0, 7) == 0) ? 32'd0 : $urandom,
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver: checks each result transaction against the oldest pending one
  // and then decides whether it will be ready in the next cycle.
  always @(posedge clk) begin
    dispatch_result_t got;
    dispatch_result_t want;
    int               pick;

    if (!rst && m_tvalid && m_tready) begin
      got = '{kind: m_tuser, slot: m_tdata[2:0], last: m_tlast, tick: m_tdata[34:3]};
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: kind %0d slot %0d last %0b tick %0d",
                 $realtime, got.kind, got.slot, got.last, got.tick);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: expected kind %0d slot %0d last %0b tick %0d,", $realtime,
                   want.kind, want.slot, want.last, want.tick,
                   " got kind %0d slot %0d last %0b tick %0d",
                   got.kind, got.slot, got.last, got.tick);
          errors++;
        end
      end
    end
    if (hold_go && !hold_done) begin
      stall_left = PRESSURE_HOLD;
      hold_done  = 1'b1;
    end
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (no_idle) begin
      m_tready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        stall_left = (pick < 96) ? $urandom_range(0, 2) : $urandom_range(15, 50);
      end
    end
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $realtime,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    sched_filled = 0;
    sched_tick   = '0;
    foreach (slot_period[i]) begin
      slot_period[i]   = '0;
      slot_last_run[i] = '0;
      slot_prio[i]     = '0;
      slot_enabled[i]  = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_fill_table();
    test_full_table();
    test_enable_disable();
    test_backpressure();
    test_random_mix();

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    // Anything the block emits after this point shows up as unexpected.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
